/* hw/rtl/obb_pkg.sv */
// ----------------------------------------------------------------------------
// Oriented box overlap test package
// Widths, sine polynomial coefficients and shared types of the overlap core.
// ----------------------------------------------------------------------------
package obb_pkg;

  localparam int POS_W    = 24;  // center coordinate
  localparam int ANG_W    = 16;  // binary angle
  localparam int HS_W     = 16;  // half size
  localparam int D_W      = 25;  // center difference
  localparam int T_W      = 17;  // polynomial argument, Q16 in 0..1
  localparam int U_W      = 17;  // argument squared, Q16
  localparam int P_W      = 32;  // Horner accumulator, Q28
  localparam int M_W      = 50;  // Horner product
  localparam int MAG_Q_W  = 17;  // first-quadrant sine magnitude
  localparam int SC_W     = 18;  // signed sine or cosine, Q16
  localparam int SQ_W     = 36;  // product of two unit vector parts
  localparam int DOT_W    = 37;  // dot product of two unit vectors
  localparam int MAG_W    = 34;  // magnitude of such a dot product
  localparam int CP_W     = 43;  // center offset times unit vector part
  localparam int PSUM_W   = 44;  // projected center offset
  localparam int PROJ_W   = 42;  // magnitude of projected center offset
  localparam int RAD_W    = 50;  // half size times dot product magnitude
  localparam int SUM_W    = 52;  // sum of projected radii
  localparam int DIST_W   = 58;  // projected center distance, Q32
  localparam int LATENCY  = 12;  // cycles from accept to result strobe
  localparam int N_LANE   = 4;   // sine evaluations per transaction
  localparam int N_AXIS   = 4;
  localparam int N_RPROD  = 12;

  localparam logic signed [P_W-1:0] SIN_C1 = 32'sd421657428;
  localparam logic signed [P_W-1:0] SIN_C3 = -32'sd173399667;
  localparam logic signed [P_W-1:0] SIN_C5 = 32'sd21392326;
  localparam logic signed [P_W-1:0] SIN_C7 = -32'sd1256749;
  localparam logic signed [P_W-1:0] SIN_C9 = 32'sd43068;

  localparam logic [T_W-1:0] T_ONE = 17'd65536;
  localparam logic [MAG_Q_W-1:0] Q16_ONE = 17'd65536;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // Values that ride along with the sine pipeline.
  typedef struct packed {
    logic [1:0]            q_a;
    logic [1:0]            q_b;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic [HS_W-1:0]       ahl;
    logic [HS_W-1:0]       ahw;
    logic [HS_W-1:0]       bhl;
    logic [HS_W-1:0]       bhw;
  } side_t;

  // Product divided by 65536, truncated toward zero.
  function automatic logic signed [P_W-1:0] trunc_q16(input logic signed [M_W-1:0] prod);
    logic signed [M_W-1:0] adj;
    adj = prod[M_W-1] ? (prod + M_W'(65535)) : prod;
    adj = adj >>> 16;
    return adj[P_W-1:0];
  endfunction

endpackage

/* hw/rtl/oriented_box_overlap_test_core.sv */
// ----------------------------------------------------------------------------
// Oriented box overlap test core
// Separating axis test of two 2D oriented boxes in fixed point.
// ----------------------------------------------------------------------------
// The core takes one transaction in every clock cycle while busy is low and
// returns each result in order, with out_valid high for one cycle. The
// receiver cannot hold results off, so each result must be taken in the
// cycle it appears. The pipeline runs through the argument stage, the
// squaring stage, one multiplier stage per Horner step, the folding stage,
// the projection products, the dot products, the radius products and the
// compare. busy is high only during reset and the cycle after it.
module oriented_box_overlap_test_core import obb_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [POS_W-1:0] in_a_center_x,
  input  logic signed [POS_W-1:0] in_a_center_y,
  input  logic [ANG_W-1:0]        in_a_angle,
  input  logic [HS_W-1:0]         in_a_half_len,
  input  logic [HS_W-1:0]         in_a_half_wid,
  input  logic signed [POS_W-1:0] in_b_center_x,
  input  logic signed [POS_W-1:0] in_b_center_y,
  input  logic [ANG_W-1:0]        in_b_angle,
  input  logic [HS_W-1:0]         in_b_half_len,
  input  logic [HS_W-1:0]         in_b_half_wid,
  output logic                    out_valid,
  output logic                    out_overlap
);

  logic                    busy_r;
  logic [LATENCY:1]        v_r;
  logic [LATENCY:1]        v_nxt;

  side_t                   side_r   [1:10];
  side_t                   side_nxt;

  logic [T_W-1:0]          t_r      [1:6][0:N_LANE-1];
  logic [T_W-1:0]          t_nxt    [0:N_LANE-1];
  logic [U_W-1:0]          u_r      [2:5][0:N_LANE-1];
  logic [U_W-1:0]          u_nxt    [0:N_LANE-1];
  logic signed [M_W-1:0]   hp_r     [3:7][0:N_LANE-1];
  logic signed [M_W-1:0]   hp_nxt   [3:7][0:N_LANE-1];
  logic signed [SC_W-1:0]  sc_r     [0:N_LANE-1];
  logic signed [SC_W-1:0]  sc_nxt   [0:N_LANE-1];
  logic signed [SQ_W-1:0]  pr_r     [0:7];
  logic signed [SQ_W-1:0]  pr_nxt   [0:7];
  logic signed [CP_W-1:0]  cp_r     [0:7];
  logic signed [CP_W-1:0]  cp_nxt   [0:7];
  logic [MAG_W-1:0]        mg_r     [0:3];
  logic [MAG_W-1:0]        mg_nxt   [0:3];
  logic [PROJ_W-1:0]       pj_r     [10:11][0:N_AXIS-1];
  logic [PROJ_W-1:0]       pj_nxt   [0:N_AXIS-1];
  logic [RAD_W-1:0]        rp_r     [0:N_RPROD-1];
  logic [RAD_W-1:0]        rp_nxt   [0:N_RPROD-1];
  logic                    ovl_r;
  logic                    ovl_nxt;

  assign busy        = busy_r;
  assign out_valid   = v_r[LATENCY];
  assign out_overlap = ovl_r;

  // Stage 1: polynomial arguments and center offsets.
  always_comb begin
    t_nxt[0] = {1'b0, in_a_angle[ANG_W-3:0], 2'b00};
    t_nxt[1] = T_ONE - t_nxt[0];
    t_nxt[2] = {1'b0, in_b_angle[ANG_W-3:0], 2'b00};
    t_nxt[3] = T_ONE - t_nxt[2];
    side_nxt.q_a = in_a_angle[ANG_W-1:ANG_W-2];
    side_nxt.q_b = in_b_angle[ANG_W-1:ANG_W-2];
    side_nxt.dx  = {in_b_center_x[POS_W-1], in_b_center_x}
                 - {in_a_center_x[POS_W-1], in_a_center_x};
    side_nxt.dy  = {in_b_center_y[POS_W-1], in_b_center_y}
                 - {in_a_center_y[POS_W-1], in_a_center_y};
    side_nxt.ahl = in_a_half_len;
    side_nxt.ahw = in_a_half_wid;
    side_nxt.bhl = in_b_half_len;
    side_nxt.bhw = in_b_half_wid;
  end

  // Stages 2 to 7: squared argument and the Horner chain.
  always_comb begin
    logic [2*T_W-1:0]      sq;
    logic signed [P_W-1:0] acc;
    for (int l = 0; l < N_LANE; l++) begin
      sq       = t_r[1][l] * t_r[1][l];
      u_nxt[l] = sq[U_W+15:16];
      hp_nxt[3][l] = M_W'(SIN_C9) * M_W'($signed({1'b0, u_r[2][l]}));
      acc = SIN_C7 + trunc_q16(hp_r[3][l]);
      hp_nxt[4][l] = M_W'(acc) * M_W'($signed({1'b0, u_r[3][l]}));
      acc = SIN_C5 + trunc_q16(hp_r[4][l]);
      hp_nxt[5][l] = M_W'(acc) * M_W'($signed({1'b0, u_r[4][l]}));
      acc = SIN_C3 + trunc_q16(hp_r[5][l]);
      hp_nxt[6][l] = M_W'(acc) * M_W'($signed({1'b0, u_r[5][l]}));
      acc = SIN_C1 + trunc_q16(hp_r[6][l]);
      hp_nxt[7][l] = M_W'(acc) * M_W'($signed({1'b0, t_r[6][l]}));
    end
  end

  // Stage 8: rounding, clamping and quadrant folding.
  always_comb begin
    logic signed [M_W-1:0]    rv;
    logic [MAG_Q_W-1:0]       mag [0:N_LANE-1];
    logic signed [SC_W-1:0]   sv;
    logic signed [SC_W-1:0]   cv;
    logic [1:0]               q;
    for (int l = 0; l < N_LANE; l++) begin
      rv = (hp_r[7][l] + M_W'(134217728)) >>> 28;
      if (rv < 0) begin
        mag[l] = '0;
      end else if (rv > M_W'(65536)) begin
        mag[l] = Q16_ONE;
      end else begin
        mag[l] = rv[MAG_Q_W-1:0];
      end
    end
    for (int b = 0; b < 2; b++) begin
      sv = $signed({1'b0, mag[2*b]});
      cv = $signed({1'b0, mag[2*b+1]});
      q  = (b == 0) ? side_r[7].q_a : side_r[7].q_b;
      // Lane 2b holds the cosine, lane 2b+1 the sine of the box.
      case (q)
        QUAD_0: begin
          sc_nxt[2*b] = cv;  sc_nxt[2*b+1] = sv;
        end
        QUAD_1: begin
          sc_nxt[2*b] = -sv; sc_nxt[2*b+1] = cv;
        end
        QUAD_2: begin
          sc_nxt[2*b] = -cv; sc_nxt[2*b+1] = -sv;
        end
        default: begin
          sc_nxt[2*b] = sv;  sc_nxt[2*b+1] = -cv;
        end
      endcase
    end
  end

  // Stage 9: unit vector products and center offset products.
  always_comb begin
    logic signed [SQ_W-1:0] ac, as_v, bc, bs;
    logic signed [CP_W-1:0] dx, dy, acw, asw, bcw, bsw;
    ac   = SQ_W'(sc_r[0]);
    as_v = SQ_W'(sc_r[1]);
    bc   = SQ_W'(sc_r[2]);
    bs   = SQ_W'(sc_r[3]);
    pr_nxt[0] = ac * ac;
    pr_nxt[1] = as_v * as_v;
    pr_nxt[2] = bc * bc;
    pr_nxt[3] = bs * bs;
    pr_nxt[4] = ac * bc;
    pr_nxt[5] = as_v * bs;
    pr_nxt[6] = ac * bs;
    pr_nxt[7] = as_v * bc;
    dx  = CP_W'(side_r[8].dx);
    dy  = CP_W'(side_r[8].dy);
    acw = CP_W'(sc_r[0]);
    asw = CP_W'(sc_r[1]);
    bcw = CP_W'(sc_r[2]);
    bsw = CP_W'(sc_r[3]);
    cp_nxt[0] = dx * acw;
    cp_nxt[1] = dy * asw;
    cp_nxt[2] = dx * asw;
    cp_nxt[3] = dy * acw;
    cp_nxt[4] = dx * bcw;
    cp_nxt[5] = dy * bsw;
    cp_nxt[6] = dx * bsw;
    cp_nxt[7] = dy * bcw;
  end

  // Stage 10: dot products and projected center offsets, as magnitudes.
  // Mixed terms: P is the dot of both length axes, Q the cross term.
  always_comb begin
    logic signed [DOT_W-1:0]  d   [0:3];
    logic signed [DOT_W-1:0]  da;
    logic signed [PSUM_W-1:0] p   [0:N_AXIS-1];
    logic signed [PSUM_W-1:0] pa;
    d[0] = DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]);
    d[1] = DOT_W'(pr_r[2]) + DOT_W'(pr_r[3]);
    d[2] = DOT_W'(pr_r[4]) + DOT_W'(pr_r[5]);
    d[3] = DOT_W'(pr_r[6]) - DOT_W'(pr_r[7]);
    for (int i = 0; i < 4; i++) begin
      da        = d[i][DOT_W-1] ? -d[i] : d[i];
      mg_nxt[i] = da[MAG_W-1:0];
    end
    p[0] = PSUM_W'(cp_r[0]) + PSUM_W'(cp_r[1]);
    p[1] = PSUM_W'(cp_r[3]) - PSUM_W'(cp_r[2]);
    p[2] = PSUM_W'(cp_r[4]) + PSUM_W'(cp_r[5]);
    p[3] = PSUM_W'(cp_r[7]) - PSUM_W'(cp_r[6]);
    for (int i = 0; i < N_AXIS; i++) begin
      pa        = p[i][PSUM_W-1] ? -p[i] : p[i];
      pj_nxt[i] = pa[PROJ_W-1:0];
    end
  end

  // Stage 11: half size times dot product magnitude.
  always_comb begin
    logic [RAD_W-1:0] na, nb, pm, qm, ahl, ahw, bhl, bhw;
    na  = RAD_W'(mg_r[0]);
    nb  = RAD_W'(mg_r[1]);
    pm  = RAD_W'(mg_r[2]);
    qm  = RAD_W'(mg_r[3]);
    ahl = RAD_W'(side_r[10].ahl);
    ahw = RAD_W'(side_r[10].ahw);
    bhl = RAD_W'(side_r[10].bhl);
    bhw = RAD_W'(side_r[10].bhw);
    rp_nxt[0]  = na * ahl;
    rp_nxt[1]  = na * ahw;
    rp_nxt[2]  = nb * bhl;
    rp_nxt[3]  = nb * bhw;
    rp_nxt[4]  = pm * ahl;
    rp_nxt[5]  = qm * ahw;
    rp_nxt[6]  = qm * ahl;
    rp_nxt[7]  = pm * ahw;
    rp_nxt[8]  = pm * bhl;
    rp_nxt[9]  = qm * bhw;
    rp_nxt[10] = qm * bhl;
    rp_nxt[11] = pm * bhw;
  end

  // Stage 12: compare the center distance against the radius sum per axis.
  always_comb begin
    logic [SUM_W-1:0]   rs   [0:N_AXIS-1];
    logic [DIST_W-1:0]  cdist;
    logic [N_AXIS-1:0]  sep;
    rs[0] = SUM_W'(rp_r[0]) + SUM_W'(rp_r[8])  + SUM_W'(rp_r[9]);
    rs[1] = SUM_W'(rp_r[1]) + SUM_W'(rp_r[10]) + SUM_W'(rp_r[11]);
    rs[2] = SUM_W'(rp_r[4]) + SUM_W'(rp_r[5])  + SUM_W'(rp_r[2]);
    rs[3] = SUM_W'(rp_r[6]) + SUM_W'(rp_r[7])  + SUM_W'(rp_r[3]);
    for (int i = 0; i < N_AXIS; i++) begin
      cdist  = {pj_r[11][i], 16'b0};
      sep[i] = cdist > DIST_W'(rs[i]);
    end
    ovl_nxt = ~|sep;
  end

  always_comb begin
    v_nxt = {v_r[LATENCY-1:1], start & ~busy_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      v_r    <= '0;
    end else begin
      busy_r <= 1'b0;
      v_r    <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r[1] <= side_nxt;
    for (int k = 2; k <= 10; k++) side_r[k] <= side_r[k-1];
    for (int l = 0; l < N_LANE; l++) begin
      t_r[1][l] <= t_nxt[l];
      for (int k = 2; k <= 6; k++) t_r[k][l] <= t_r[k-1][l];
      u_r[2][l] <= u_nxt[l];
      for (int k = 3; k <= 5; k++) u_r[k][l] <= u_r[k-1][l];
      for (int k = 3; k <= 7; k++) hp_r[k][l] <= hp_nxt[k][l];
      sc_r[l] <= sc_nxt[l];
    end
    for (int i = 0; i < 8; i++) begin
      pr_r[i] <= pr_nxt[i];
      cp_r[i] <= cp_nxt[i];
    end
    for (int i = 0; i < 4; i++) mg_r[i] <= mg_nxt[i];
    for (int i = 0; i < N_AXIS; i++) begin
      pj_r[10][i] <= pj_nxt[i];
      pj_r[11][i] <= pj_r[10][i];
    end
    for (int i = 0; i < N_RPROD; i++) rp_r[i] <= rp_nxt[i];
    ovl_r <= ovl_nxt;
  end

endmodule

/* hw/rtl/obb_checker.sv */
// ----------------------------------------------------------------------------
// Oriented box overlap port checker
// Watches the core's ports for result timing and basic geometric sanity.
// ----------------------------------------------------------------------------
module obb_checker import obb_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic signed [POS_W-1:0] in_a_center_x,
  input logic signed [POS_W-1:0] in_a_center_y,
  input logic [ANG_W-1:0]        in_a_angle,
  input logic [HS_W-1:0]         in_a_half_len,
  input logic [HS_W-1:0]         in_a_half_wid,
  input logic signed [POS_W-1:0] in_b_center_x,
  input logic signed [POS_W-1:0] in_b_center_y,
  input logic [ANG_W-1:0]        in_b_angle,
  input logic [HS_W-1:0]         in_b_half_len,
  input logic [HS_W-1:0]         in_b_half_wid,
  input logic                    out_valid,
  input logic                    out_overlap
);

  logic accept;
  assign accept = start & ~busy;

  // Every accepted transaction yields its result a fixed time later.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##12 out_valid)
    else $error("result strobe missing after an accepted transaction");

  // No result without a transaction accepted at the matching edge.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 12))
    else $error("result strobe without a matching transaction");

  // Boxes sharing a center always overlap.
  a_same_center: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_a_center_x == in_b_center_x && in_a_center_y == in_b_center_y)
      |-> ##12 out_overlap)
    else $error("boxes with a common center reported as separated");

  // Nothing comes out of the pipeline right after reset.
  a_reset_clears: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind oriented_box_overlap_test_core obb_checker u_obb_checker (.*);
